// ===== src/sts_pkg.sv =====
// Shared types and constants for the scale tone sine sequencer.
package sts_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_BASE_STEP   = 2'd0,
        REG_AMPLITUDE   = 2'd1,
        REG_SAMPLES     = 2'd2,
        REG_NOTE_COUNT  = 2'd3
    } reg_index_t;

    localparam logic [31:0] BASE_STEP_RST  = 32'd42852282;
    localparam logic [14:0] AMPLITUDE_RST  = 15'd5000;
    localparam logic [19:0] SAMPLES_RST    = 20'd44100;
    localparam logic [6:0]  NOTE_COUNT_RST = 7'd0;

    localparam int RATIO_FRAC_BITS = 28;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [14:0] FULL_SCALE  = 15'd32767;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic mul;
        logic scl;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tick_go;
        logic out_free;
    } status_t;

endpackage

// ===== src/sts_ctrl.sv =====
// Sequencing controller: input acceptance, datapath stage steps, output hand-off.
module sts_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sts_pkg::status_t status,
    output sts_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_SCALE,
        S_DONE
    } state_t;

    state_t state_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd      = '0;
        cmd.load = (state_reg == S_IDLE) && in_valid;
        cmd.rd   = (state_reg == S_READ);
        cmd.mul  = (state_reg == S_MUL);
        cmd.scl  = (state_reg == S_SCALE);
        cmd.emit = (state_reg == S_DONE) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= status.tick_go ? S_READ : S_DONE;
                    end
                end
                S_READ:  state_reg <= S_MUL;
                S_MUL:   state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/sts_datapath.sv =====
// Datapath: config registers, ratio memory, phase accumulator, sine ROM, output register.
module sts_datapath #(
    parameter int MAX_NOTES    = 64,
    parameter int PHASE_BITS   = 32,
    parameter int SINE_ENTRIES = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic [1:0]       opcode,
    input  logic [5:0]       note_slot,
    input  logic [31:0]      ratio_value,
    input  sts_pkg::cmd_t    cmd,
    output sts_pkg::status_t status,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_sample,
    output logic [6:0]       out_note,
    output logic             out_last,
    output logic             out_playing
);

    localparam int AW  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int QS  = PHASE_BITS - 2;
    localparam int SEB = $clog2(SINE_ENTRIES);
    localparam int FW  = QS + SEB + 1;
    localparam int IW  = $clog2(SINE_ENTRIES + 1);

    // quarter-wave magnitude, Q30 Taylor series evaluated at elaboration
    function automatic logic [14:0] sine_val(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        if (k >= SINE_ENTRIES)
        begin
            return sts_pkg::FULL_SCALE;
        end
        x    = (sts_pkg::HALF_PI_Q30 * 64'(k)) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = (sum >= term) ? sum - term : 64'd0;
        v    = (sum * 64'd32767 + 64'd536870912) >> 30;
        return (v > 64'd32767) ? sts_pkg::FULL_SCALE : v[14:0];
    endfunction

    logic [14:0] sine_rom [SINE_ENTRIES + 1];

    for (genvar k = 0; k <= SINE_ENTRIES; k++)
    begin : g_rom
        assign sine_rom[k] = sine_val(k);
    end

    // config
    logic [31:0] base_step_reg;
    logic [14:0] amplitude_reg;
    logic [19:0] samples_reg;
    logic [6:0]  note_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step_reg  <= sts_pkg::BASE_STEP_RST;
            amplitude_reg  <= sts_pkg::AMPLITUDE_RST;
            samples_reg    <= sts_pkg::SAMPLES_RST;
            note_count_reg <= sts_pkg::NOTE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sts_pkg::REG_BASE_STEP:  base_step_reg  <= cfg_data;
                sts_pkg::REG_AMPLITUDE:  amplitude_reg  <= cfg_data[14:0];
                sts_pkg::REG_SAMPLES:    samples_reg    <= cfg_data[19:0];
                sts_pkg::REG_NOTE_COUNT: note_count_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ratio memory
    logic [31:0] ratio_mem [MAX_NOTES];
    logic [15:0] slot_wide;
    logic [15:0] rd_wide;
    logic        slot_ok;
    logic        op_write;
    logic        op_start;
    logic        op_tick;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [6:0]            note_reg;
    logic [19:0]           count_reg;
    logic                  active_reg;

    assign op_write  = (opcode == sts_pkg::OP_WRITE);
    assign op_start  = (opcode == sts_pkg::OP_START);
    assign op_tick   = (opcode == sts_pkg::OP_TICK);
    assign slot_wide = {10'd0, note_slot};
    assign slot_ok   = (slot_wide < 16'(MAX_NOTES));
    assign rd_wide   = {9'd0, note_reg - 7'd1};

    logic [31:0] ratio_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && op_write && slot_ok)
        begin
            ratio_mem[slot_wide[AW-1:0]] <= ratio_value;
        end
        if (cmd.rd)
        begin
            ratio_rd_reg <= ratio_mem[rd_wide[AW-1:0]];
        end
    end

    // stage 1: sine index
    logic [QS-1:0]   frac;
    logic [FW-1:0]   idx_prod;
    logic [FW-1:0]   idx_shift;
    logic [IW-1:0]   idx_raw;
    logic [IW-1:0]   idx_next;
    logic [IW-1:0]   idx_reg;
    logic [1:0]      quad_reg;

    assign frac      = phase_reg[QS-1:0];
    assign idx_prod  = FW'(frac) * FW'(SINE_ENTRIES);
    assign idx_shift = idx_prod >> QS;
    assign idx_raw   = idx_shift[IW-1:0];
    assign idx_next  = phase_reg[QS] ? (IW'(SINE_ENTRIES) - idx_raw) : idx_raw;

    // stage 2: rom read and ratio product
    logic [14:0] mag_reg;
    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            idx_reg  <= idx_next;
            quad_reg <= phase_reg[PHASE_BITS-1 -: 2];
        end
        if (cmd.mul)
        begin
            mag_reg  <= sine_rom[idx_reg];
            prod_reg <= 64'(base_step_reg) * 64'(ratio_rd_reg);
        end
    end

    // stage 3: scale and state update
    logic [29:0]           scaled;
    logic [15:0]           mag16;
    logic [15:0]           sample_val;
    logic [95:0]           step_ext;
    logic [79:0]           base_ext;
    logic [PHASE_BITS-1:0] step;
    logic [19:0]           count_inc;
    logic [19:0]           spn;
    logic [10:0]           lim;
    logic [7:0]            note_inc;
    logic                  note_end;
    logic                  seq_end;

    assign scaled     = 30'(amplitude_reg) * 30'(mag_reg);
    assign mag16      = {1'b0, scaled[29:15]};
    assign sample_val = quad_reg[1] ? (16'd0 - mag16) : mag16;
    assign step_ext   = {32'd0, prod_reg} >> sts_pkg::RATIO_FRAC_BITS;
    assign base_ext   = {48'd0, base_step_reg};
    assign step       = (note_reg == 7'd0) ? base_ext[PHASE_BITS-1:0]
                                           : step_ext[PHASE_BITS-1:0];
    assign count_inc  = count_reg + 20'd1;
    assign spn        = (samples_reg == 20'd0) ? 20'd1 : samples_reg;
    assign note_end   = (count_inc >= spn);
    assign lim        = ({4'd0, note_count_reg} > 11'(MAX_NOTES)) ? 11'(MAX_NOTES)
                                                                : {4'd0, note_count_reg};
    assign note_inc   = {1'b0, note_reg} + 8'd1;
    assign seq_end    = ({3'd0, note_inc} > lim);

    logic [15:0] res_sample_reg;
    logic [6:0]  res_note_reg;
    logic        res_last_reg;
    logic        res_playing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            note_reg   <= '0;
            count_reg  <= '0;
            active_reg <= 1'b0;
        end
        else if (cmd.load && op_start)
        begin
            phase_reg  <= '0;
            note_reg   <= '0;
            count_reg  <= '0;
            active_reg <= 1'b1;
        end
        else if (cmd.scl)
        begin
            if (note_end)
            begin
                phase_reg <= '0;
                count_reg <= '0;
                if (seq_end)
                begin
                    active_reg <= 1'b0;
                    note_reg   <= '0;
                end
                else
                begin
                    note_reg <= note_inc[6:0];
                end
            end
            else
            begin
                phase_reg <= phase_reg + step;
                count_reg <= count_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_sample_reg  <= '0;
            res_last_reg    <= 1'b0;
            res_note_reg    <= op_start ? 7'd0 : note_reg;
            res_playing_reg <= op_start | active_reg;
        end
        else if (cmd.scl)
        begin
            res_sample_reg  <= sample_val;
            res_note_reg    <= note_reg;
            res_last_reg    <= note_end && seq_end;
            res_playing_reg <= !(note_end && seq_end);
        end
    end

    // output register
    logic        out_valid_reg;
    logic [15:0] out_sample_reg;
    logic [6:0]  out_note_reg;
    logic        out_last_reg;
    logic        out_playing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_sample_reg  <= res_sample_reg;
            out_note_reg    <= res_note_reg;
            out_last_reg    <= res_last_reg;
            out_playing_reg <= res_playing_reg;
        end
    end

    assign status.tick_go  = op_tick && active_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_sample  = out_sample_reg;
    assign out_note    = out_note_reg;
    assign out_last    = out_last_reg;
    assign out_playing = out_playing_reg;

endmodule

// ===== src/scale_tone_sine_sequencer.sv =====
// Top level of the scale tone sine sequencer.
//
// Channel  Direction  Beat contents
// s_*      in         tuser[1:0] opcode; tdata[5:0] note_slot, [37:6] ratio_value
// m_*      out        tdata[15:0] sample, [22:16] note_number; tlast last; tuser playing
// cfg_*    in         cfg_index selects the register, cfg_data carries its value
//
// A sample tick while playing passes from accept to output through ratio memory
// read, sine ROM read plus ratio multiply, amplitude scaling, then the output load.
// Other beats go straight to the output load. One beat is in flight at a time; a beat can be taken
// while the previous result still sits in the output register.
// Reset is asynchronous, active low; the ratio memory is not cleared.
// A stalled output holds the controller in its hand-off state.
module scale_tone_sine_sequencer #(
    parameter int MAX_NOTES    = 64,
    parameter int PHASE_BITS   = 32,
    parameter int SINE_ENTRIES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // note_slot[5:0], ratio_value[37:6], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample[15:0], note_number[22:16], zero pad
    output logic        m_tlast,
    output logic        m_tuser    // playing
);

    sts_pkg::cmd_t    cmd;
    sts_pkg::status_t status;
    logic [15:0]      out_sample;
    logic [6:0]       out_note;

    sts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sts_datapath #(
        .MAX_NOTES    (MAX_NOTES),
        .PHASE_BITS   (PHASE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (s_tuser),
        .note_slot   (s_tdata[5:0]),
        .ratio_value (s_tdata[37:6]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_sample  (out_sample),
        .out_note    (out_note),
        .out_last    (m_tlast),
        .out_playing (m_tuser)
    );

    assign m_tdata = {1'b0, out_note, out_sample};

endmodule

// ===== src/sts_checker.sv =====
// Port-level checks for the scale tone sine sequencer, bound to the top level.
module sts_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // one beat at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is in flight");

    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tuser)
        else $error("last beat still reports playing");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && !m_tlast |-> m_tdata[15:0] == 16'd0)
        else $error("nonzero sample while idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

endmodule

bind scale_tone_sine_sequencer sts_checker u_sts_checker (.*);
